>>> src/arfw_pkg.sv
// Shared types and constants for the ADC range fault and ack watchdog.
package arfw_pkg;

  localparam int unsigned SAMPLE_W  = 24;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_ACK    = 2'd2,
    MODE_CHECK  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_FAULT    = 2'd1,
    EV_REPLACED = 2'd2,
    EV_MISSED   = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOW  = 8'd0,
    REG_WINDOW_HIGH = 8'd1,
    REG_FAULT_LIMIT = 8'd2,
    REG_ACK_TIMEOUT = 8'd3
  } reg_idx_e;

endpackage

>>> src/arfw_if.sv
// Request, result and register-write channel interfaces for the watchdog.
interface arfw_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic [arfw_pkg::SAMPLE_W-1:0]  sample_value;
  logic [arfw_pkg::SEQ_W-1:0]     seq_number;
  logic [arfw_pkg::TIME_W-1:0]    clock_now;

  modport source (output valid, mode, sample_value, seq_number, clock_now, input ready);
  modport sink   (input valid, mode, sample_value, seq_number, clock_now, output ready);
endinterface

interface arfw_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     event_code;
  logic                           ack_accepted;
  logic                           deadline_valid;
  logic [arfw_pkg::TIME_W-1:0]    deadline_time;

  modport source (output valid, event_code, ack_accepted, deadline_valid, deadline_time,
                  input ready);
  modport sink   (input valid, event_code, ack_accepted, deadline_valid, deadline_time,
                  output ready);
endinterface

interface arfw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [arfw_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [arfw_pkg::CFG_DAT_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> src/adc_range_fault_and_ack_watchdog.sv
// Top level: sensor range fault counter and report acknowledgement watchdog.
// Result: a request's result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle; the result register is refilled in the same
//   cycle it is drained, so requests stall only while a result waits unread.
// Reset: rst_ni clears the run counter, pending ack and result valid; window is
//   [0, 2^24-1], fault check and ack tracking are disabled. Any register write
//   with a known index also clears the run counter and the pending ack.
module adc_range_fault_and_ack_watchdog (
  input  logic        clk_i,
  input  logic        rst_ni,
  arfw_req_if.sink    req_i,
  arfw_rsp_if.source  rsp_o,
  arfw_cfg_if.sink    cfg_i
);

  // Register file
  logic [arfw_pkg::SAMPLE_W-1:0] win_low_q, win_high_q;
  logic [arfw_pkg::RUN_W-1:0]    fault_limit_q;
  logic [arfw_pkg::TIME_W-1:0]   ack_timeout_q;

  // Monitor state
  logic [arfw_pkg::RUN_W-1:0]    run_q, run_d;
  logic                          pend_q, pend_d;
  logic [arfw_pkg::SEQ_W-1:0]    pend_seq_q, pend_seq_d;
  logic [arfw_pkg::TIME_W-1:0]   pend_due_q, pend_due_d;

  // Result register
  logic                          rsp_valid_q;
  arfw_pkg::event_e              ev_q, ev_d;
  logic                          acc_q, acc_d;
  logic                          dl_valid_q, dl_valid_d;
  logic [arfw_pkg::TIME_W-1:0]   dl_time_q, dl_time_d;

  logic                          req_fire, cfg_fire, cfg_hit;
  logic                          in_window, ack_hit, due_reached;
  logic [arfw_pkg::RUN_W-1:0]    run_inc;
  logic [arfw_pkg::TIME_W-1:0]   due_new, due_diff;
  arfw_pkg::mode_e               mode;

  // Result slot is free when empty or being drained this cycle.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign cfg_i.ready = 1'b1;
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    case (cfg_i.reg_index)
      arfw_pkg::REG_WINDOW_LOW,
      arfw_pkg::REG_WINDOW_HIGH,
      arfw_pkg::REG_FAULT_LIMIT,
      arfw_pkg::REG_ACK_TIMEOUT: cfg_hit = 1'b1;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  assign mode      = arfw_pkg::mode_e'(req_i.mode);
  assign in_window = (req_i.sample_value >= win_low_q) && (req_i.sample_value <= win_high_q);
  // Run saturates before the compare against the limit.
  assign run_inc   = (run_q == arfw_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
  assign ack_hit   = pend_q && (pend_seq_q == req_i.seq_number);
  assign due_new   = req_i.clock_now + ack_timeout_q;
  // Wrapping compare: deadline reached when (now - due) is non-negative.
  assign due_diff  = req_i.clock_now - pend_due_q;
  assign due_reached = !due_diff[arfw_pkg::TIME_W-1];

  // Single-pass item evaluation against the current state.
  always_comb begin
    run_d      = run_q;
    pend_d     = pend_q;
    pend_seq_d = pend_seq_q;
    pend_due_d = pend_due_q;
    ev_d       = arfw_pkg::EV_NONE;
    acc_d      = 1'b0;
    dl_valid_d = 1'b0;
    dl_time_d  = '0;
    case (mode)
      arfw_pkg::MODE_SAMPLE: begin
        if (fault_limit_q != '0) begin
          if (in_window) begin
            run_d = '0;
          end else if (run_inc >= fault_limit_q) begin
            run_d = '0;
            ev_d  = arfw_pkg::EV_FAULT;
          end else begin
            run_d = run_inc;
          end
        end
      end
      arfw_pkg::MODE_REPORT: begin
        if (ack_timeout_q != '0) begin
          if (pend_q) begin
            ev_d = arfw_pkg::EV_REPLACED;
          end else begin
            pend_d     = 1'b1;
            pend_seq_d = req_i.seq_number;
            pend_due_d = due_new;
            dl_valid_d = 1'b1;
            dl_time_d  = due_new;
          end
        end
      end
      arfw_pkg::MODE_ACK: begin
        if (ack_hit) begin
          pend_d = 1'b0;
          acc_d  = 1'b1;
        end
      end
      arfw_pkg::MODE_CHECK: begin
        if (pend_q && due_reached) begin
          pend_d = 1'b0;
          ev_d   = arfw_pkg::EV_MISSED;
        end
      end
      default: ;
    endcase
  end

  // Registers; a mapped write wipes monitor state (user must write only while idle, unenforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low_q     <= '0;
      win_high_q    <= {arfw_pkg::SAMPLE_W{1'b1}};
      fault_limit_q <= '0;
      ack_timeout_q <= '0;
    end else if (cfg_fire) begin
      case (cfg_i.reg_index)
        arfw_pkg::REG_WINDOW_LOW:  win_low_q     <= cfg_i.wdata[arfw_pkg::SAMPLE_W-1:0];
        arfw_pkg::REG_WINDOW_HIGH: win_high_q    <= cfg_i.wdata[arfw_pkg::SAMPLE_W-1:0];
        arfw_pkg::REG_FAULT_LIMIT: fault_limit_q <= cfg_i.wdata[arfw_pkg::RUN_W-1:0];
        arfw_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= cfg_i.wdata[arfw_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= '0;
      pend_q     <= 1'b0;
      pend_seq_q <= '0;
      pend_due_q <= '0;
    end else if (cfg_fire && cfg_hit) begin
      run_q      <= '0;
      pend_q     <= 1'b0;
      pend_seq_q <= '0;
      pend_due_q <= '0;
    end else if (req_fire) begin
      run_q      <= run_d;
      pend_q     <= pend_d;
      pend_seq_q <= pend_seq_d;
      pend_due_q <= pend_due_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      ev_q       <= ev_d;
      acc_q      <= acc_d;
      dl_valid_q <= dl_valid_d;
      dl_time_q  <= dl_time_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.event_code     = ev_q;
  assign rsp_o.ack_accepted   = acc_q;
  assign rsp_o.deadline_valid = dl_valid_q;
  assign rsp_o.deadline_time  = dl_time_q;

  // Fault run only moves while the check is enabled.
  a_run_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fault_limit_q == '0) |-> (run_q == '0))
    else $error("outside run nonzero with fault check disabled");

  // Nothing can be pending with tracking disabled.
  a_pend_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ack_timeout_q == '0) |-> !pend_q)
    else $error("ack pending with tracking disabled");

  // A new deadline never comes with any other event.
  a_dl_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && dl_valid_q) |-> (ev_q == arfw_pkg::EV_NONE && !acc_q && pend_q))
    else $error("deadline result mixed with other outcome");

  // A matched ack closes the pending entry.
  a_ack_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && mode == arfw_pkg::MODE_ACK && ack_hit) |=> (!pend_q && acc_q))
    else $error("matched ack left entry pending");

endmodule

>>> sim/arfw_outcome_checker.sv
// Watchdog outcome checker: tracks accepted requests, predicts each result and compares it.
module arfw_outcome_checker
  import arfw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  arfw_req_if  req,
  arfw_rsp_if  rsp,
  arfw_cfg_if  cfg,
  output int   fail_count,
  output int   outstanding,
  output int   faults_seen,
  output int   replaced_seen,
  output int   missed_seen,
  output int   acks_seen,
  output int   deadlines_seen
);

  typedef struct packed {
    event_e            ev;
    logic              accepted;
    logic              dl_valid;
    logic [TIME_W-1:0] dl_time;
  } outcome_t;

  // Mirror of the register file and the tracking state.
  logic [SAMPLE_W-1:0] win_low;
  logic [SAMPLE_W-1:0] win_high;
  logic [RUN_W-1:0]    limit;
  logic [TIME_W-1:0]   timeout;
  logic [RUN_W-1:0]    run_len;
  logic                pending;
  logic [SEQ_W-1:0]    open_seq;
  logic [TIME_W-1:0]   open_due;

  outcome_t awaited_outcomes[$];

  function automatic void clear_tracking();
    run_len  = '0;
    pending  = 1'b0;
    open_seq = '0;
    open_due = '0;
  endfunction

  // Unknown index: dropped, tracking state kept.
  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_WINDOW_LOW:  win_low  = data[SAMPLE_W-1:0];
      REG_WINDOW_HIGH: win_high = data[SAMPLE_W-1:0];
      REG_FAULT_LIMIT: limit    = data[RUN_W-1:0];
      REG_ACK_TIMEOUT: timeout  = data[TIME_W-1:0];
      default:         return;
    endcase
    clear_tracking();
  endfunction

  function automatic outcome_t outcome_for(mode_e mode, logic [SAMPLE_W-1:0] smp,
                                           logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] now);
    outcome_t          o;
    logic [TIME_W-1:0] lag;
    o.ev       = EV_NONE;
    o.accepted = 1'b0;
    o.dl_valid = 1'b0;
    o.dl_time  = '0;
    case (mode)
      MODE_SAMPLE: begin
        if (limit != '0) begin
          if (smp >= win_low && smp <= win_high) begin
            run_len = '0;
          end else begin
            if (run_len != RUN_MAX) run_len = run_len + 1'b1;
            if (run_len >= limit) begin
              run_len = '0;
              o.ev    = EV_FAULT;
            end
          end
        end
      end
      MODE_REPORT: begin
        if (timeout != '0) begin
          if (pending) begin
            o.ev = EV_REPLACED;
          end else begin
            open_seq   = seq;
            open_due   = now + timeout;
            pending    = 1'b1;
            o.dl_valid = 1'b1;
            o.dl_time  = open_due;
          end
        end
      end
      MODE_ACK: begin
        if (pending && open_seq == seq) begin
          pending    = 1'b0;
          o.accepted = 1'b1;
        end
      end
      default: begin
        // deadline reached when the wrapped difference is not negative
        lag = now - open_due;
        if (pending && !lag[TIME_W-1]) begin
          pending = 1'b0;
          o.ev    = EV_MISSED;
        end
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: result error on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic compare_result();
    outcome_t want;
    if (awaited_outcomes.size() == 0) begin
      report_mismatch("unrequested result", 32'(rsp.event_code), '0);
      return;
    end
    want = awaited_outcomes.pop_front();
    if (rsp.event_code !== want.ev)
      report_mismatch("event_code", 32'(rsp.event_code), 32'(want.ev));
    if (rsp.ack_accepted !== want.accepted)
      report_mismatch("ack_accepted", 32'(rsp.ack_accepted), 32'(want.accepted));
    if (rsp.deadline_valid !== want.dl_valid)
      report_mismatch("deadline_valid", 32'(rsp.deadline_valid), 32'(want.dl_valid));
    if (rsp.deadline_time !== want.dl_time)
      report_mismatch("deadline_time", rsp.deadline_time, want.dl_time);
    case (want.ev)
      EV_FAULT:    faults_seen++;
      EV_REPLACED: replaced_seen++;
      EV_MISSED:   missed_seen++;
      default:     ;
    endcase
    if (want.accepted) acks_seen++;
    if (want.dl_valid) deadlines_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low        = '0;
      win_high       = '1;
      limit          = '0;
      timeout        = '0;
      clear_tracking();
      awaited_outcomes.delete();
      fail_count     = 0;
      faults_seen    = 0;
      replaced_seen  = 0;
      missed_seen    = 0;
      acks_seen      = 0;
      deadlines_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) apply_write(cfg.reg_index, cfg.wdata);
      if (req.valid && req.ready)
        awaited_outcomes.push_back(outcome_for(mode_e'(req.mode), req.sample_value,
                                               req.seq_number, req.clock_now));
      if (rsp.valid && rsp.ready) compare_result();
    end
    outstanding = awaited_outcomes.size();
  end

endmodule

>>> sim/adc_range_fault_and_ack_watchdog_test.sv
// Testbench top: directed and random requests into the watchdog, random back-pressure, verdict.
module adc_range_fault_and_ack_watchdog_test;
  import arfw_pkg::*;

  // Hard stop: far beyond the slowest correct run (long gaps on every request plus
  // long result stalls on every result).
  localparam int unsigned RUN_LIMIT   = 10_000_000;
  localparam int          PHASE_COUNT = 6;
  localparam int          STRAY_FIRST = int'(REG_ACK_TIMEOUT) + 1;  // first unmapped index
  localparam int          STRAY_LAST  = (1 << CFG_IDX_W) - 1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  arfw_req_if req ();
  arfw_rsp_if rsp ();
  arfw_cfg_if cfg ();

  int fail_count;
  int outstanding;
  int faults_seen;
  int replaced_seen;
  int missed_seen;
  int acks_seen;
  int deadlines_seen;

  int requests_sent;
  int settings_done;
  bit steady_req;   // sender never pauses while set
  bit steady_rsp;   // receiver starts no new stall while set

  // Stimulus-side view of the current settings, used only to aim the random requests
  // at interesting corners (window edges, deadlines).
  logic [SAMPLE_W-1:0] lo_now;
  logic [SAMPLE_W-1:0] hi_now;
  logic [TIME_W-1:0]   timeout_now;
  logic [TIME_W-1:0]   wall;       // rolling time base, started near the wrap point
  logic [SEQ_W-1:0]    last_seq;
  logic [TIME_W-1:0]   last_due;

  adc_range_fault_and_ack_watchdog DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  arfw_outcome_checker outcome_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req            (req),
    .rsp            (rsp),
    .cfg            (cfg),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .faults_seen    (faults_seen),
    .replaced_seen  (replaced_seen),
    .missed_seen    (missed_seen),
    .acks_seen      (acks_seen),
    .deadlines_seen (deadlines_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(RUN_LIMIT);
    $display("adc_range_fault_and_ack_watchdog: mismatch");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: ready drops for random stretches; none starts while steady_rsp is set.
  initial begin
    int stall;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        stall--;
      end else begin
        rsp.ready <= 1'b1;
        if (!steady_rsp && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // One request. valid stays high across back-to-back requests; it only drops when
  // a gap is inserted, so it never gets two updates in one step.
  task automatic send(mode_e mode, logic [SAMPLE_W-1:0] smp, logic [SEQ_W-1:0] seq,
                      logic [TIME_W-1:0] now);
    int gap;
    gap = steady_req ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.mode         <= mode;
    req.sample_value <= smp;
    req.seq_number   <= seq;
    req.clock_now    <= now;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stop sending and wait for every predicted result; then idle before any register
  // write so the block is fully quiet.
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // Leaves cfg.valid high; the caller lowers it after the last write of a batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
  endtask

  // Writes all four registers. Bits above each register's width carry random junk
  // that the block must drop.
  task automatic configure(logic [SAMPLE_W-1:0] lo, logic [SAMPLE_W-1:0] hi,
                           logic [RUN_W-1:0] lim, logic [TIME_W-1:0] tmo);
    logic [CFG_DAT_W-1:0] junk;
    junk = $urandom();
    if ($urandom_range(0, 1)) write_reg(REG_ACK_TIMEOUT, tmo);
    write_reg(REG_WINDOW_LOW, {junk[CFG_DAT_W-1:SAMPLE_W], lo});
    write_reg(REG_WINDOW_HIGH, {~junk[CFG_DAT_W-1:SAMPLE_W], hi});
    write_reg(REG_FAULT_LIMIT, {junk[CFG_DAT_W-1:RUN_W], lim});
    write_reg(REG_ACK_TIMEOUT, tmo);
    cfg.valid <= 1'b0;
    lo_now      = lo;
    hi_now      = hi;
    timeout_now = tmo;
    settings_done++;
  endtask

  // Samples aimed at both window edges, the field extremes, or anywhere.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return lo_now;
      1:       return lo_now - 1'b1;
      2:       return hi_now;
      3:       return hi_now + 1'b1;
      4:       return '0;
      5:       return '1;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Random request. Reports feed the acks and deadline checks that follow, so most
  // acks carry the last reported sequence and half the checks land right around the
  // last deadline; the rest is noise. Fields that a mode ignores stay random.
  task automatic random_request(int sample_pct);
    int                pick;
    logic [TIME_W-1:0] now;
    logic [SEQ_W-1:0]  seq;
    pick = $urandom_range(0, 99);
    wall = wall + $urandom_range(1, 8);
    if (pick < sample_pct) begin
      send(MODE_SAMPLE, pick_sample(), $urandom(), $urandom());
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        seq = $urandom();
        now = $urandom_range(0, 3) == 0 ? $urandom() : wall;
        last_seq = seq;
        last_due = now + timeout_now;
        send(MODE_REPORT, SAMPLE_W'($urandom()), seq, now);
      end else if (pick < 70) begin
        case ($urandom_range(0, 7))
          0:       seq = $urandom();
          1:       seq = last_seq ^ (32'd1 << $urandom_range(0, SEQ_W - 1));
          default: seq = last_seq;
        endcase
        send(MODE_ACK, SAMPLE_W'($urandom()), seq, $urandom());
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: now = last_due + $urandom_range(0, 4) - 2;
          5:             now = last_due + 32'h7FFF_FFFF;
          6:             now = last_due + 32'h8000_0000;
          7:             now = wall;
          default:       now = $urandom();
        endcase
        send(MODE_CHECK, SAMPLE_W'($urandom()), $urandom(), now);
      end
    end
  endtask

  initial begin
    int                   phase_len;
    int                   sample_pct;
    logic [SAMPLE_W-1:0]  lo;
    req.valid        <= 1'b0;
    req.mode         <= MODE_SAMPLE;
    req.sample_value <= '0;
    req.seq_number   <= '0;
    req.clock_now    <= '0;
    cfg.valid        <= 1'b0;
    cfg.reg_index    <= REG_WINDOW_LOW;
    cfg.wdata        <= '0;
    requests_sent = 0;
    settings_done = 0;
    steady_req    = 1'b1;
    steady_rsp    = 1'b0;
    lo_now        = '0;
    hi_now        = '1;
    timeout_now   = '0;
    last_seq      = '0;
    last_due      = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part ----
    // Reset settings: fault check and ack tracking both off, so nothing happens.
    send(MODE_SAMPLE, '0, '0, '0);
    send(MODE_SAMPLE, '1, '1, '1);
    send(MODE_REPORT, '0, 32'h1234_5678, '0);   // tracking off: no deadline
    send(MODE_ACK, '0, 32'h1234_5678, '0);      // nothing pending
    send(MODE_CHECK, '0, '0, '1);               // nothing pending
    drain();

    // Window [0x100, 0xFFFF], fault after two outside samples, 100-tick deadline.
    configure(24'h00_0100, 24'h00_FFFF, 8'd2, 32'd100);
    steady_req = 1'b0;
    send(MODE_SAMPLE, 24'h00_00FF, '0, '0);     // just below: run 1
    send(MODE_SAMPLE, 24'h01_0000, '0, '0);     // just above: run 2, fault
    send(MODE_SAMPLE, 24'h00_0100, '0, '0);     // low edge inside
    send(MODE_SAMPLE, 24'hFF_FFFF, '0, '0);     // outside, run 1
    send(MODE_SAMPLE, 24'h00_FFFF, '0, '0);     // high edge inside, run cleared
    send(MODE_REPORT, '0, 32'hA5A5_0001, 32'hFFFF_FFF0);  // deadline wraps to 0x54
    send(MODE_REPORT, '0, 32'h5A5A_0002, '0);             // replaced, deadline kept
    send(MODE_ACK, '0, 32'h5A5A_0002, '0);                // wrong sequence
    send(MODE_CHECK, '0, '0, 32'h0000_0053);              // one tick early
    send(MODE_CHECK, '0, '0, 32'h8000_0054);              // half a wrap ahead: negative
    send(MODE_CHECK, '0, '0, 32'h8000_0053);              // largest positive distance: missed
    send(MODE_REPORT, '0, '1, 32'd5);
    send(MODE_ACK, '0, '1, '0);                           // matches
    send(MODE_ACK, '0, '1, '0);                           // already closed
    send(MODE_CHECK, '0, '0, 32'd105);                    // nothing pending
    drain();

    // Empty window, largest fault limit, largest timeout (deadline one tick behind).
    configure('1, '0, RUN_MAX, '1);
    send(MODE_REPORT, '0, '0, 32'd1);                     // deadline 0
    send(MODE_CHECK, '0, '0, '0);                         // exactly at deadline: missed
    send(MODE_SAMPLE, 24'h80_0000, '0, '0);               // outside any empty window
    drain();

    // ---- Random part ----
    wall = 32'hFFFF_F000;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      phase_len  = 250;
      sample_pct = 45;
      lo = SAMPLE_W'($urandom());
      case (phase)
        0: configure('0, '1, 8'd1, 32'd1);
        1: begin
          // all samples outside: long enough for a run to reach the top limit
          configure('1, '0, RUN_MAX, '1);
          phase_len  = 400;
          sample_pct = 90;
        end
        2: configure(lo, lo + SAMPLE_W'($urandom_range(0, 4096)), '0, '0);
        3: configure(lo, SAMPLE_W'($urandom()), 8'($urandom_range(2, 6)), $urandom());
        4: configure(lo >> 4, lo, 8'($urandom_range(1, 3)), $urandom_range(1, 40));
        default: begin
          configure(SAMPLE_W'($urandom_range(0, 255)), SAMPLE_W'($urandom()),
                    8'($urandom()), $urandom_range(2, 20));
          phase_len = 200;
        end
      endcase
      if (phase == 2) phase_len = 200;

      for (int n = 0; n < phase_len; n++) begin
        // bursts with no idling on either side at the start of odd phases
        steady_req = (phase % 2 == 1) && n < 60;
        steady_rsp = steady_req;
        if (phase == 2 && n == 100) drain();   // sender waits for every result
        if (phase == 4 && n == 120) begin
          // unmapped index: must neither change a register nor clear tracking
          drain();
          write_reg(CFG_IDX_W'($urandom_range(STRAY_FIRST, STRAY_LAST)), $urandom());
          cfg.valid <= 1'b0;
        end
        random_request(sample_pct);
      end
      drain();
    end
    steady_req = 1'b0;
    steady_rsp = 1'b0;

    // All requests are in; drain() waited for the last result, then the bench idles on
    // in case the block emits anything stray.
    repeat (4) @(posedge clk_i);

    $display("run: %0d requests over %0d register settings; %0d threshold faults,",
             requests_sent, settings_done, faults_seen);
    $display("run: %0d replaced reports, %0d missed acks, %0d acks accepted, %0d deadlines",
             replaced_seen, missed_seen, acks_seen, deadlines_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("adc_range_fault_and_ack_watchdog: match");
    end else begin
      $display("adc_range_fault_and_ack_watchdog: mismatch");
    end
    $finish;
  end

endmodule
